FILE: rtl/trc_pkg.sv
// shared types and constants of the tristate remote code decoder
`timescale 1ns / 1ps
`default_nettype none

package trc_pkg;

    localparam int OUT_TIME_BITS = 48;
    localparam int PIN_SLOTS     = 12;
    localparam int HALF_PINS     = 6;
    localparam int POS_BITS      = 4;
    localparam int PINS_BITS     = 12;
    localparam int SYNC_SHIFT    = 3;
    localparam int FIFO_DEPTH    = 4;
    localparam int FIFO_PTR_BITS = 2;
    localparam int FIFO_CNT_BITS = 3;
    localparam int MAX_RESULTS   = 3;
    localparam int CFG_IDX_BITS  = 1;

    localparam logic [1:0] KIND_BIT  = 2'd0;
    localparam logic [1:0] KIND_ADDR = 2'd1;
    localparam logic [1:0] KIND_DATA = 2'd2;
    localparam logic [1:0] KIND_SYNC = 2'd3;

    localparam logic [1:0] SYM_ZERO    = 2'd0;
    localparam logic [1:0] SYM_ONE     = 2'd1;
    localparam logic [1:0] SYM_FLOAT   = 2'd2;
    localparam logic [1:0] SYM_UNKNOWN = 2'd3;

    localparam logic [1:0] PIN_ON      = 2'd0;
    localparam logic [1:0] PIN_OFF     = 2'd1;
    localparam logic [1:0] PIN_UNKNOWN = 2'd2;

    localparam logic [CFG_IDX_BITS-1:0] REG_DECODE_ENABLE  = 1'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_EMIT_CODE_WORD = 1'd1;

    typedef struct packed {
        logic [1:0]               event_kind;
        logic [1:0]               bit_symbol;
        logic [POS_BITS-1:0]      bit_position;
        logic [OUT_TIME_BITS-1:0] span_start;
        logic [OUT_TIME_BITS-1:0] span_end;
        logic [PINS_BITS-1:0]     address_pins;
        logic [PINS_BITS-1:0]     data_pins;
        logic                     last_of_run;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/trc_if.sv
// request channels of the tristate remote code decoder
`timescale 1ns / 1ps
`default_nettype none

interface trc_edge_if;
    import trc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [OUT_TIME_BITS-1:0] edge_time;
    modport source (output valid, output edge_time, input ready);
    modport sink (input valid, input edge_time, output ready);
endinterface

interface trc_evt_if;
    import trc_pkg::*;
    logic                     valid;
    logic                     ready;
    logic [1:0]               event_kind;
    logic [1:0]               bit_symbol;
    logic [POS_BITS-1:0]      bit_position;
    logic [OUT_TIME_BITS-1:0] span_start;
    logic [OUT_TIME_BITS-1:0] span_end;
    logic [PINS_BITS-1:0]     address_pins;
    logic [PINS_BITS-1:0]     data_pins;
    logic                     last_of_run;
    modport source (output valid, output event_kind, output bit_symbol, output bit_position,
                    output span_start, output span_end, output address_pins,
                    output data_pins, output last_of_run, input ready);
    modport sink (input valid, input event_kind, input bit_symbol, input bit_position,
                  input span_start, input span_end, input address_pins,
                  input data_pins, input last_of_run, output ready);
endinterface

interface trc_cfg_if;
    import trc_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic                    data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: rtl/tristate_remote_code_decoder_core.sv
// top level of the tristate remote code decoder
// usage:
//   i_edge carries one request per edge on the data line: its sample count.
//   o_evt returns bit, address word, data word and sync requests in order;
//   last_of_run marks the final request caused by one edge.
//   i_cfg writes decode_enable (index 0) and emit_code_word (index 1); it is
//   always ready and must only be used while the decoder is idle.
// timing:
//   an edge is registered, decoded from that register once the queue has
//   room, and its results land in a four-entry result queue whose head is
//   offered on o_evt. one edge per cycle is taken while the queue
//   drains at one request per cycle; a sync edge in code-word mode puts
//   three requests in the queue and holds the input until it drains back.
//   the input stage takes a new edge while older results wait in the queue.
// reset:
//   synchronous, active low; the queue empties, the decoder disarms,
//   decode_enable returns to 1 and emit_code_word to 0.
// stalls:
//   when o_evt.ready stays low the queue fills and i_edge.ready drops;
//   nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module tristate_remote_code_decoder_core #(
    parameter int BITS_PER_WORD = 12,
    parameter int TIME_BITS     = 48
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    trc_edge_if.sink    i_edge,
    trc_evt_if.source   o_evt,
    trc_cfg_if.sink     i_cfg
);
    import trc_pkg::*;

    localparam int XW = TIME_BITS + 3;
    localparam int SW = TIME_BITS + 4;
    localparam logic [TIME_BITS-1:0] TMASK = {TIME_BITS{1'b1}};

    function automatic logic is_long(input logic [TIME_BITS-1:0] v,
                                     input logic [TIME_BITS-1:0] r);
        logic [XW-1:0] v3;
        logic [XW-1:0] r3;
        v3 = XW'(v);
        r3 = XW'(r);
        return (v3 >= (r3 << 1)) && (v3 <= ((r3 << 2) + r3));
    endfunction

    function automatic logic is_equal(input logic [TIME_BITS-1:0] v,
                                      input logic [TIME_BITS-1:0] r);
        logic [XW-1:0] v3;
        logic [XW-1:0] r3;
        v3 = XW'(v);
        r3 = XW'(r);
        return ((v3 << 1) >= r3) && ((v3 << 1) <= ((r3 << 1) + r3));
    endfunction

    // configuration
    logic r_decode_enable;
    logic r_emit_code_word;

    // input stage
    logic                 r_in_valid;
    logic [TIME_BITS-1:0] r_t;

    // decoder state
    logic                 r_armed,        n_armed;
    logic [TIME_BITS-1:0] r_prev,         n_prev;
    logic [TIME_BITS-1:0] r_bit_start,    n_bit_start;
    logic [TIME_BITS-1:0] r_iv [3];
    logic [TIME_BITS-1:0] n_iv [3];
    logic [1:0]           r_iv_idx,       n_iv_idx;
    logic [POS_BITS-1:0]  r_bits_done,    n_bits_done;
    logic [1:0]           r_sym [PIN_SLOTS];
    logic [TIME_BITS-1:0] r_word_start,   n_word_start;
    logic [TIME_BITS-1:0] r_half_time,    n_half_time;
    logic [TIME_BITS-1:0] r_ignore_until, n_ignore_until;
    logic                 r_ignoring,     n_ignoring;

    // result queue
    t_result                  r_fifo [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_head;
    logic [FIFO_PTR_BITS-1:0] r_tail;
    logic [FIFO_CNT_BITS-1:0] r_count;

    logic                 room;
    logic                 fire;
    logic                 process;
    logic                 sym_we;
    logic [1:0]           sym_val;
    logic [TIME_BITS-1:0] pulse;
    logic [SW-1:0]        sync_sum;
    logic [TIME_BITS-1:0] sync_end;
    logic [1:0]           push_n;
    t_result              res [MAX_RESULTS];
    logic [PINS_BITS-1:0] addr_pins;
    logic [PINS_BITS-1:0] data_pins;
    logic                 pop;

    assign room  = r_count <= FIFO_CNT_BITS'(FIFO_DEPTH - MAX_RESULTS);
    assign fire  = r_in_valid && room;
    assign pulse = r_t - r_prev;

    assign sync_sum = SW'(r_t) + (SW'(pulse) << SYNC_SHIFT);
    assign sync_end = (sync_sum > SW'(TMASK)) ? TMASK : sync_sum[TIME_BITS-1:0];

    always_comb begin
        for (int i = 0; i < HALF_PINS; i++) begin
            case (r_sym[i])
                SYM_ZERO:    addr_pins[2*i +: 2] = PIN_ON;
                SYM_UNKNOWN: addr_pins[2*i +: 2] = PIN_UNKNOWN;
                default:     addr_pins[2*i +: 2] = PIN_OFF;
            endcase
            data_pins[2*i +: 2] = r_sym[i + HALF_PINS];
        end
    end

    always_comb begin
        if (is_long(r_iv[1], r_iv[0]) && is_equal(r_iv[2], r_iv[0])
                && is_long(pulse, r_iv[0])) begin
            sym_val = SYM_ZERO;
        end else if (is_long(r_iv[0], r_iv[1]) && is_equal(r_iv[0], r_iv[2])
                && is_long(r_iv[0], pulse)) begin
            sym_val = SYM_ONE;
        end else if (is_long(r_iv[1], r_iv[0]) && is_long(r_iv[2], r_iv[0])
                && is_equal(pulse, r_iv[0])) begin
            sym_val = SYM_FLOAT;
        end else begin
            sym_val = SYM_UNKNOWN;
        end
    end

    // decode step for the registered edge
    always_comb begin
        n_armed        = r_armed;
        n_prev         = r_prev;
        n_bit_start    = r_bit_start;
        n_iv           = r_iv;
        n_iv_idx       = r_iv_idx;
        n_bits_done    = r_bits_done;
        n_word_start   = r_word_start;
        n_half_time    = r_half_time;
        n_ignore_until = r_ignore_until;
        n_ignoring     = r_ignoring;
        sym_we         = 1'b0;
        push_n         = 2'd0;
        process        = 1'b0;
        for (int k = 0; k < MAX_RESULTS; k++) begin
            res[k] = '0;
        end

        if (fire && r_decode_enable) begin
            if (!r_ignoring || (r_t > r_ignore_until)) begin
                process    = 1'b1;
                n_ignoring = 1'b0;
            end
        end

        if (process) begin
            if (!r_armed) begin
                n_armed      = 1'b1;
                n_prev       = r_t;
                n_bit_start  = r_t;
                n_word_start = r_t;
                n_iv_idx     = 2'd0;
                n_bits_done  = '0;
            end else begin
                n_prev = r_t;
                if (r_bits_done < POS_BITS'(BITS_PER_WORD)) begin
                    if (r_iv_idx < 2'd3) begin
                        n_iv[r_iv_idx] = pulse;
                        n_iv_idx       = r_iv_idx + 2'd1;
                    end else begin
                        sym_we              = 1'b1;
                        res[0].event_kind   = KIND_BIT;
                        res[0].bit_symbol   = sym_val;
                        res[0].bit_position = r_bits_done;
                        res[0].span_start   = OUT_TIME_BITS'(r_bit_start);
                        res[0].span_end     = OUT_TIME_BITS'(r_t);
                        res[0].last_of_run  = 1'b1;
                        push_n              = 2'd1;
                        n_bit_start         = r_t;
                        n_iv_idx            = 2'd0;
                        n_bits_done         = r_bits_done + 1'b1;
                        if (n_bits_done == POS_BITS'(HALF_PINS)) begin
                            n_half_time = r_t;
                        end
                    end
                end else begin
                    if (r_emit_code_word) begin
                        res[0].event_kind   = KIND_ADDR;
                        res[0].span_start   = OUT_TIME_BITS'(r_word_start);
                        res[0].span_end     = OUT_TIME_BITS'(r_half_time);
                        res[0].address_pins = addr_pins;
                        res[1].event_kind   = KIND_DATA;
                        res[1].span_start   = OUT_TIME_BITS'(r_half_time);
                        res[1].span_end     = OUT_TIME_BITS'(r_bit_start);
                        res[1].data_pins    = data_pins;
                        res[2].event_kind   = KIND_SYNC;
                        res[2].span_start   = OUT_TIME_BITS'(r_bit_start);
                        res[2].span_end     = OUT_TIME_BITS'(sync_end);
                        res[2].last_of_run  = 1'b1;
                        push_n              = 2'd3;
                    end else begin
                        res[0].event_kind   = KIND_SYNC;
                        res[0].span_start   = OUT_TIME_BITS'(r_bit_start);
                        res[0].span_end     = OUT_TIME_BITS'(sync_end);
                        res[0].last_of_run  = 1'b1;
                        push_n              = 2'd1;
                    end
                    n_ignore_until = sync_end;
                    n_ignoring     = 1'b1;
                    n_armed        = 1'b0;
                    n_bits_done    = '0;
                    n_iv_idx       = 2'd0;
                end
            end
        end
    end

    assign i_edge.ready = !r_in_valid || room;
    assign i_cfg.ready  = 1'b1;
    assign pop          = (r_count != '0) && o_evt.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decode_enable  <= 1'b1;
            r_emit_code_word <= 1'b0;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_DECODE_ENABLE:  r_decode_enable  <= i_cfg.data;
                REG_EMIT_CODE_WORD: r_emit_code_word <= i_cfg.data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_edge.ready) begin
            r_in_valid <= i_edge.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_edge.ready && i_edge.valid) begin
            r_t <= TIME_BITS'(i_edge.edge_time);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed        <= 1'b0;
            r_prev         <= '0;
            r_bit_start    <= '0;
            r_iv           <= '{default: '0};
            r_iv_idx       <= 2'd0;
            r_bits_done    <= '0;
            r_word_start   <= '0;
            r_half_time    <= '0;
            r_ignore_until <= '0;
            r_ignoring     <= 1'b0;
        end else begin
            r_armed        <= n_armed;
            r_prev         <= n_prev;
            r_bit_start    <= n_bit_start;
            r_iv           <= n_iv;
            r_iv_idx       <= n_iv_idx;
            r_bits_done    <= n_bits_done;
            r_word_start   <= n_word_start;
            r_half_time    <= n_half_time;
            r_ignore_until <= n_ignore_until;
            r_ignoring     <= n_ignoring;
        end
    end

    // symbol store, no reset
    always_ff @(posedge i_clk) begin
        if (sym_we) begin
            r_sym[r_bits_done] <= sym_val;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_RESULTS; k++) begin
            if (2'(k) < push_n) begin
                r_fifo[r_tail + FIFO_PTR_BITS'(k)] <= res[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            r_tail  <= r_tail + FIFO_PTR_BITS'(push_n);
            r_head  <= r_head + FIFO_PTR_BITS'(pop);
            r_count <= r_count + FIFO_CNT_BITS'(push_n) - FIFO_CNT_BITS'(pop);
        end
    end

    assign o_evt.valid        = r_count != '0;
    assign o_evt.event_kind   = r_fifo[r_head].event_kind;
    assign o_evt.bit_symbol   = r_fifo[r_head].bit_symbol;
    assign o_evt.bit_position = r_fifo[r_head].bit_position;
    assign o_evt.span_start   = r_fifo[r_head].span_start;
    assign o_evt.span_end     = r_fifo[r_head].span_end;
    assign o_evt.address_pins = r_fifo[r_head].address_pins;
    assign o_evt.data_pins    = r_fifo[r_head].data_pins;
    assign o_evt.last_of_run  = r_fifo[r_head].last_of_run;

endmodule

`default_nettype wire

FILE: rtl/trc_chk.sv
// port checker of the tristate remote code decoder and its bind
`timescale 1ns / 1ps
`default_nettype none

module trc_chk (
    input wire                              i_clk,
    input wire                              i_rst_n,
    input wire                              i_out_valid,
    input wire                              i_out_ready,
    input wire [1:0]                        i_kind,
    input wire [1:0]                        i_symbol,
    input wire [trc_pkg::POS_BITS-1:0]      i_position,
    input wire                              i_last
);
    import trc_pkg::*;

    // a stalled request stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result request dropped while stalled");

    // an address word is followed at once by its data word
    a_addr_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_kind == KIND_ADDR
        |=> i_out_valid && i_kind == KIND_DATA)
        else $error("address word not followed by data word");

    // a data word is followed at once by the sync
    a_data_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_ready && i_kind == KIND_DATA
        |=> i_out_valid && i_kind == KIND_SYNC)
        else $error("data word not followed by sync");

    // only bits carry a symbol and a position; bits and syncs close a run
    a_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_kind == KIND_BIT || (i_symbol == '0 && i_position == '0))
                        && (i_last == (i_kind == KIND_BIT || i_kind == KIND_SYNC)))
        else $error("result fields do not match their kind");

endmodule

bind tristate_remote_code_decoder_core trc_chk u_trc_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_evt.valid),
    .i_out_ready (o_evt.ready),
    .i_kind      (o_evt.event_kind),
    .i_symbol    (o_evt.bit_symbol),
    .i_position  (o_evt.bit_position),
    .i_last      (o_evt.last_of_run)
);

`default_nettype wire

FILE: verif/tb_top.sv
// self-checking testbench of the tristate remote code decoder: edge traffic against a predictor
`timescale 1ns / 1ps

module tb_top;
    import trc_pkg::*;

    localparam int WORD_BITS   = 12;
    localparam int EDGE_ITEMS  = 480;
    localparam int TAIL_ITEMS  = 64;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [OUT_TIME_BITS-1:0] TIME_MAX = '1;

    logic i_clk;
    logic i_rst_n;

    trc_edge_if edge_ch ();
    trc_evt_if  evt_ch ();
    trc_cfg_if  cfg_ch ();

    tristate_remote_code_decoder_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_edge  (edge_ch),
        .o_evt   (evt_ch),
        .i_cfg   (cfg_ch)
    );

    // decoder state as the predictor sees it
    logic                     cfg_enable    = 1'b1;
    logic                     cfg_code_word = 1'b0;
    logic                     dec_armed     = 1'b0;
    logic [OUT_TIME_BITS-1:0] last_edge     = '0;
    logic [OUT_TIME_BITS-1:0] bit_begin     = '0;
    logic [OUT_TIME_BITS-1:0] gap_store [3] = '{default: '0};
    int                       gap_count     = 0;
    int                       bits_seen     = 0;
    logic [1:0]               pin_syms [PIN_SLOTS] = '{default: '0};
    logic [OUT_TIME_BITS-1:0] frame_begin   = '0;
    logic [OUT_TIME_BITS-1:0] mid_word      = '0;
    logic [OUT_TIME_BITS-1:0] quiet_until   = '0;
    logic                     quiet         = 1'b0;

    t_result                  pending_events [$];
    logic [OUT_TIME_BITS-1:0] line_time   = '0;
    int                       edges_sent  = 0;
    int                       fail_count  = 0;
    int                       cycle_count = 0;
    bit                       idling_on   = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic bit in_ratio(input logic [OUT_TIME_BITS-1:0] v, base,
                                    input int lo_n, lo_d, hi_n, hi_d);
        return 64'(v) * 64'(lo_d) >= 64'(base) * 64'(lo_n) &&
               64'(v) * 64'(hi_d) <= 64'(base) * 64'(hi_n);
    endfunction

    function automatic logic [1:0] bit_class(input logic [OUT_TIME_BITS-1:0] e0, e1, e2, e3);
        if (in_ratio(e1, e0, 2, 1, 5, 1) && in_ratio(e2, e0, 1, 2, 3, 2) &&
            in_ratio(e3, e0, 2, 1, 5, 1))
            return SYM_ZERO;
        if (in_ratio(e0, e1, 2, 1, 5, 1) && in_ratio(e0, e2, 1, 2, 3, 2) &&
            in_ratio(e0, e3, 2, 1, 5, 1))
            return SYM_ONE;
        if (in_ratio(e1, e0, 2, 1, 5, 1) && in_ratio(e2, e0, 2, 1, 5, 1) &&
            in_ratio(e3, e0, 1, 2, 3, 2))
            return SYM_FLOAT;
        return SYM_UNKNOWN;
    endfunction

    // returns 1 when the edge was not ignored
    function automatic bit decode_edge(input logic [OUT_TIME_BITS-1:0] t);
        logic [OUT_TIME_BITS-1:0] pulse;
        logic [OUT_TIME_BITS-1:0] sync_end;
        logic [1:0]               cls;
        logic [1:0]               pin;
        logic [PINS_BITS-1:0]     ap;
        logic [PINS_BITS-1:0]     dp;
        t_result                  r;
        if (!cfg_enable)
            return 1'b0;
        if (quiet) begin
            if (t <= quiet_until)
                return 1'b0;
            quiet = 1'b0;
        end
        if (!dec_armed) begin
            dec_armed   = 1'b1;
            last_edge   = t;
            bit_begin   = t;
            frame_begin = t;
            gap_count   = 0;
            bits_seen   = 0;
            return 1'b1;
        end
        pulse     = t - last_edge;
        last_edge = t;
        if (bits_seen < WORD_BITS) begin
            if (gap_count < 3) begin
                gap_store[gap_count] = pulse;
                gap_count++;
                return 1'b1;
            end
            cls = bit_class(gap_store[0], gap_store[1], gap_store[2], pulse);
            pin_syms[bits_seen] = cls;
            r              = '0;
            r.event_kind   = KIND_BIT;
            r.bit_symbol   = cls;
            r.bit_position = POS_BITS'(bits_seen);
            r.span_start   = bit_begin;
            r.span_end     = t;
            r.last_of_run  = 1'b1;
            pending_events.push_back(r);
            bit_begin = t;
            gap_count = 0;
            bits_seen++;
            if (bits_seen == HALF_PINS)
                mid_word = t;
            return 1'b1;
        end
        if (cfg_code_word) begin
            ap = '0;
            dp = '0;
            for (int i = 0; i < HALF_PINS; i++) begin
                case (pin_syms[i])
                    SYM_ZERO:    pin = PIN_ON;
                    SYM_UNKNOWN: pin = PIN_UNKNOWN;
                    default:     pin = PIN_OFF;
                endcase
                ap[2*i +: 2] = pin;
                dp[2*i +: 2] = pin_syms[i + HALF_PINS];
            end
            r              = '0;
            r.event_kind   = KIND_ADDR;
            r.span_start   = frame_begin;
            r.span_end     = mid_word;
            r.address_pins = ap;
            pending_events.push_back(r);
            r              = '0;
            r.event_kind   = KIND_DATA;
            r.span_start   = mid_word;
            r.span_end     = bit_begin;
            r.data_pins    = dp;
            pending_events.push_back(r);
        end
        // sync end saturates at the top of the time range
        sync_end      = (pulse > (TIME_MAX - t) / 8) ? TIME_MAX : t + pulse * 8;
        r             = '0;
        r.event_kind  = KIND_SYNC;
        r.span_start  = bit_begin;
        r.span_end    = sync_end;
        r.last_of_run = 1'b1;
        pending_events.push_back(r);
        quiet_until = sync_end;
        quiet       = 1'b1;
        dec_armed   = 1'b0;
        bits_seen   = 0;
        gap_count   = 0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [63:0] want, got);
        if (want !== got) begin
            $error("%s: expected %0h, actual %0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && evt_ch.valid && evt_ch.ready) begin
            if (pending_events.size() == 0) begin
                $error("unexpected request: kind %0d, end %0h", evt_ch.event_kind,
                       evt_ch.span_end);
                fail_count++;
            end else begin
                want = pending_events.pop_front();
                check_field("event_kind", want.event_kind, evt_ch.event_kind);
                check_field("bit_symbol", want.bit_symbol, evt_ch.bit_symbol);
                check_field("bit_position", want.bit_position, evt_ch.bit_position);
                check_field("span_start", want.span_start, evt_ch.span_start);
                check_field("span_end", want.span_end, evt_ch.span_end);
                check_field("address_pins", want.address_pins, evt_ch.address_pins);
                check_field("data_pins", want.data_pins, evt_ch.data_pins);
                check_field("last_of_run", want.last_of_run, evt_ch.last_of_run);
            end
        end
    end

    // result sink with random stall bursts
    initial begin
        int stall_left;
        stall_left = 0;
        evt_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                evt_ch.ready <= 1'b0;
            end else if (idling_on && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 17);
                evt_ch.ready <= 1'b0;
            end else begin
                evt_ch.ready <= 1'b1;
            end
        end
    end

    task automatic send_edge(input logic [OUT_TIME_BITS-1:0] t);
        edge_ch.valid     <= 1'b1;
        edge_ch.edge_time <= t;
        do @(posedge i_clk); while (!edge_ch.ready);
        void'(decode_edge(t));
        edges_sent++;
        line_time = t;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            edge_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        edge_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic val);
        wait_drained();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx == REG_DECODE_ENABLE)
            cfg_enable = val;
        else
            cfg_code_word = val;
    endtask

    function automatic int unsigned long_of(input int unsigned a);
        case ($urandom_range(0, 5))
            0:       return 2 * a;
            1:       return 5 * a;
            2:       return 2 * a - 1;
            3:       return 5 * a + 1;
            default: return $urandom_range(2 * a, 5 * a);
        endcase
    endfunction

    function automatic int unsigned equal_of(input int unsigned a);
        case ($urandom_range(0, 5))
            0:       return a / 2;
            1:       return a / 2 - 1;
            2:       return 3 * a / 2;
            3:       return 3 * a / 2 + 1;
            4:       return a;
            default: return $urandom_range(a / 2, 3 * a / 2);
        endcase
    endfunction

    function automatic int unsigned pick_unit();
        if ($urandom_range(0, 7) == 0)
            return 2 * $urandom_range(1, 1 << 20);
        return 2 * $urandom_range(1, 20);
    endfunction

    function automatic logic [1:0] pick_symbol();
        case ($urandom_range(0, 9))
            0, 1, 2: return SYM_ZERO;
            3, 4, 5: return SYM_ONE;
            6, 7, 8: return SYM_FLOAT;
            default: return SYM_UNKNOWN;
        endcase
    endfunction

    // the edge intervals of one bit, shaped for the wanted class, often on a ratio bound
    task automatic send_bit(input logic [1:0] sym, input int unsigned a);
        int unsigned g [4];
        case (sym)
            SYM_ZERO: begin
                g[0] = a;
                g[1] = long_of(a);
                g[2] = equal_of(a);
                g[3] = long_of(a);
            end
            SYM_ONE: begin
                g[1] = a;
                g[0] = long_of(a);
                case ($urandom_range(0, 3))
                    0:       g[2] = g[0];
                    1:       g[2] = 2 * g[0];
                    2:       g[2] = 2 * g[0] + 1;
                    default: g[2] = g[0] - g[0] / 3;
                endcase
                case ($urandom_range(0, 2))
                    0:       g[3] = g[0] / 2;
                    1:       g[3] = g[0] / 5;
                    default: g[3] = a;
                endcase
            end
            SYM_FLOAT: begin
                g[0] = a;
                g[1] = long_of(a);
                g[2] = long_of(a);
                g[3] = equal_of(a);
            end
            default: begin
                for (int k = 0; k < 4; k++)
                    g[k] = $urandom_range(0, 6 * a);
            end
        endcase
        for (int k = 0; k < 4; k++)
            send_edge(line_time + g[k]);
    endtask

    // small steps until the decoder stands at the start of a word, or is disarmed or disabled
    task automatic realign();
        while (cfg_enable && dec_armed && (bits_seen != 0 || gap_count != 0))
            send_edge(line_time + $urandom_range(1, 20));
    endtask

    task automatic start_frame(input int unsigned a, input bit tight);
        realign();
        if (quiet && line_time <= quiet_until)
            line_time = quiet_until;
        if (!dec_armed)
            send_edge(line_time + (tight ? 1 : $urandom_range(1, 40 * a)));
    endtask

    task automatic send_frame(input int unsigned a, input bit hit_end, input bit saturate);
        logic [OUT_TIME_BITS-1:0] pulse;
        start_frame(a, 1'b0);
        repeat (WORD_BITS) send_bit(pick_symbol(), a);
        if (saturate)
            pulse = (TIME_MAX - line_time) / 2;
        else
            pulse = OUT_TIME_BITS'(a) * $urandom_range(4, 40);
        send_edge(line_time + pulse);
        repeat ($urandom_range(0, 2)) send_edge(line_time + $urandom_range(1, a));
        if (hit_end) begin
            send_edge(quiet_until);
            send_edge(quiet_until + 1);
        end
    endtask

    task automatic send_broken_frame(input int unsigned a);
        start_frame(a, 1'b0);
        repeat ($urandom_range(1, WORD_BITS - 1)) send_bit(pick_symbol(), a);
        repeat ($urandom_range(0, 3)) send_edge(line_time + $urandom_range(0, 6 * a));
    endtask

    task automatic send_noise(input int count);
        logic [OUT_TIME_BITS-1:0] t;
        repeat (count) begin
            case ($urandom_range(0, 3))
                0:       t = line_time;
                1:       t = line_time - $urandom_range(1, 1000);
                2:       t = {8'($urandom_range(0, 254)), 8'($urandom), 32'($urandom)};
                default: t = line_time + $urandom_range(1, 200);
            endcase
            // a wrapped or far jump as sync pulse would pin the window at the top
            if ((dec_armed && bits_seen == WORD_BITS) || (t < line_time && line_time < 2000))
                t = line_time + $urandom_range(1, 200);
            send_edge(t);
        end
    endtask

    task automatic test_edge_extremes();
        send_edge('0);
        repeat (4) send_edge('0);
        send_edge(TIME_MAX);
        send_edge(OUT_TIME_BITS'(5));
        send_edge(OUT_TIME_BITS'(10));
        send_edge(OUT_TIME_BITS'(15));
        realign();
    endtask

    task automatic test_register_access();
        write_reg(REG_EMIT_CODE_WORD, 1'b1);
        write_reg(REG_DECODE_ENABLE, 1'b0);
        repeat (4) send_edge(line_time + $urandom_range(1, 50));
        write_reg(REG_DECODE_ENABLE, 1'b1);
    endtask

    task automatic test_directed_frames();
        send_frame(8, 1'b1, 1'b0);
        write_reg(REG_EMIT_CODE_WORD, 1'b0);
        send_frame(2, 1'b0, 1'b0);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int pick;
        while (edges_sent < EDGE_ITEMS - TAIL_ITEMS) begin
            pick = $urandom_range(0, 19);
            if (pick < 12) begin
                send_frame(pick_unit(), $urandom_range(0, 7) == 0, 1'b0);
            end else if (pick < 14) begin
                send_noise($urandom_range(1, 8));
            end else if (pick < 16) begin
                send_broken_frame(pick_unit());
            end else if (pick == 16) begin
                write_reg(REG_EMIT_CODE_WORD, ~cfg_code_word);
            end else if (pick == 17) begin
                write_reg(REG_DECODE_ENABLE, 1'b0);
                repeat ($urandom_range(1, 4)) send_edge(line_time + $urandom_range(0, 500));
                write_reg(REG_DECODE_ENABLE, 1'b1);
            end else begin
                wait_drained();
                idling_on = ~idling_on;
            end
        end
    endtask

    // last: the window then reaches the top of the range and never closes
    task automatic test_sync_saturation();
        idling_on = 1'b0;
        write_reg(REG_EMIT_CODE_WORD, 1'b1);
        realign();
        if (quiet && line_time <= quiet_until)
            line_time = quiet_until;
        line_time = TIME_MAX - OUT_TIME_BITS'(32'h4000_0000);
        send_frame(4, 1'b1, 1'b1);
    endtask

    initial begin
        i_rst_n           <= 1'b0;
        edge_ch.valid     <= 1'b0;
        edge_ch.edge_time <= '0;
        cfg_ch.valid      <= 1'b0;
        cfg_ch.index      <= REG_DECODE_ENABLE;
        cfg_ch.data       <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edge_extremes();
        test_register_access();
        test_directed_frames();
        test_random_traffic();
        test_sync_saturation();

        edge_ch.valid <= 1'b0;
        repeat (4000) begin
            if (pending_events.size() == 0)
                break;
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (pending_events.size() != 0) begin
            $error("requests still owed at the end: %0d", pending_events.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
